[hw/rtl/card_reader_frame_receiver_top_macros.svh]
// Assertion macros shared by the checker of the frame receiver.
`ifndef CARD_READER_FRAME_RECEIVER_TOP_MACROS_SVH
`define CARD_READER_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CRFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// Next-cycle implication, disabled while reset is high.
`define CRFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

[hw/rtl/crfr_pkg.sv]
package crfr_pkg;

  localparam int PAYLOAD_BYTES_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam int BLOCK_BYTES       = 16;

  localparam logic [7:0] CMD_READ_ID     = 8'hA1;
  localparam logic [7:0] CMD_READ_BLOCK  = 8'hA3;
  localparam logic [7:0] CMD_WRITE_BLOCK = 8'hA4;
  localparam logic [7:0] STATUS_OK       = 8'h00;
  localparam logic [7:0] MIN_LENGTH      = 8'd3;

  // Byte positions within a frame.
  localparam logic [7:0] POS_START   = 8'd0;
  localparam logic [7:0] POS_LENGTH  = 8'd1;
  localparam logic [7:0] POS_COMMAND = 8'd2;
  localparam logic [7:0] POS_STATUS  = 8'd4;
  localparam logic [7:0] POS_PAYLOAD = 8'd5;

  localparam logic [1:0] KIND_READ_ID     = 2'd0;
  localparam logic [1:0] KIND_READ_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_WRITE_BLOCK = 2'd2;
  localparam logic [1:0] KIND_OTHER       = 2'd3;

  typedef struct packed {
    logic [7:0] command;
    logic [7:0] status;
    logic       checksum_ok;
    logic       length_error;
  } frame_info_t;

endpackage

[hw/rtl/crfr_front.sv]
module crfr_front #(
  parameter int PAYLOAD_BYTES = crfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  logic [7:0]                 rx_byte,
  output logic                       rec_valid,
  output crfr_pkg::frame_info_t      rec_info,
  output logic [PAYLOAD_BYTES*8-1:0] rec_payload
);
  import crfr_pkg::*;

  logic [7:0] pos, pos_next;
  logic [7:0] len, len_next;
  logic [7:0] xor_acc, xor_acc_next;
  logic [7:0] command, command_next;
  logic [7:0] status, status_next;
  logic [7:0] payload [PAYLOAD_BYTES];
  logic [7:0] payload_next [PAYLOAD_BYTES];
  logic [7:0] payload_upd [PAYLOAD_BYTES];
  logic [7:0] len_upd, command_upd, status_upd;
  logic       short_len, frame_end;

  always_comb begin
    len_upd     = (pos == POS_LENGTH) ? rx_byte : len;
    command_upd = (pos == POS_COMMAND) ? rx_byte : command;
    status_upd  = (pos == POS_STATUS) ? rx_byte : status;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      payload_upd[i] = (pos == 8'(POS_PAYLOAD + 8'(i))) ? rx_byte : payload[i];
    end
    short_len = (pos == POS_LENGTH) && (rx_byte < MIN_LENGTH);
    // The byte at position length-1 is the checksum and closes the frame.
    frame_end = (pos != POS_START) && (({1'b0, pos} + 9'd1) == {1'b0, len_upd});
    rec_valid = accept && (short_len || frame_end);

    rec_info.command      = command_upd;
    rec_info.status       = status_upd;
    rec_info.checksum_ok  = !short_len && ((~xor_acc) == rx_byte);
    rec_info.length_error = short_len;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      rec_payload[i*8 +: 8] = payload_upd[i];
    end

    pos_next     = pos;
    len_next     = len;
    xor_acc_next = xor_acc;
    command_next = command;
    status_next  = status;
    payload_next = payload;
    if (accept) begin
      if (short_len || frame_end) begin
        pos_next     = POS_START;
        len_next     = '0;
        xor_acc_next = '0;
        command_next = '0;
        status_next  = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          payload_next[i] = '0;
        end
      end else begin
        pos_next     = pos + 8'd1;
        len_next     = len_upd;
        xor_acc_next = xor_acc ^ rx_byte;
        command_next = command_upd;
        status_next  = status_upd;
        payload_next = payload_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_START;
      len     <= '0;
      xor_acc <= '0;
      command <= '0;
      status  <= '0;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
        payload[i] <= '0;
      end
    end else begin
      pos     <= pos_next;
      len     <= len_next;
      xor_acc <= xor_acc_next;
      command <= command_next;
      status  <= status_next;
      payload <= payload_next;
    end
  end

endmodule

[hw/rtl/crfr_queue.sv]
module crfr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = crfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  output logic             full
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PtrW-1:0]  wr_ptr, rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr, do_rd;

  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_valid = (count != '0);
  assign full     = (count == CntW'(DEPTH));
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

[hw/rtl/crfr_back.sv]
module crfr_back #(
  parameter int PAYLOAD_BYTES = crfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  crfr_pkg::frame_info_t      q_info,
  input  logic [PAYLOAD_BYTES*8-1:0] q_payload,
  output logic                       q_take,
  input  logic                       pop,
  output logic                       empty,
  output logic [1:0]                 frame_kind,
  output logic                       checksum_ok,
  output logic                       op_ok,
  output logic                       length_error,
  output logic [15:0]                card_type,
  output logic [31:0]                card_number,
  output logic [63:0]                block_low,
  output logic [63:0]                block_high
);
  import crfr_pkg::*;

  logic [7:0]  pb [BLOCK_BYTES];
  logic        out_valid;
  logic [1:0]  kind;
  logic [15:0] type_n;
  logic [31:0] number_n;
  logic [63:0] low_n, high_n;

  // Payload bytes that are not kept read as zero.
  for (genvar i = 0; i < BLOCK_BYTES; i++) begin : g_pb
    if (i < PAYLOAD_BYTES) begin : g_kept
      assign pb[i] = q_payload[i*8 +: 8];
    end else begin : g_zero
      assign pb[i] = '0;
    end
  end

  always_comb begin
    unique case (q_info.command)
      CMD_READ_ID:     kind = KIND_READ_ID;
      CMD_READ_BLOCK:  kind = KIND_READ_BLOCK;
      CMD_WRITE_BLOCK: kind = KIND_WRITE_BLOCK;
      default:         kind = KIND_OTHER;
    endcase
    type_n   = {pb[0], pb[1]};
    number_n = {pb[2], pb[3], pb[4], pb[5]};
    low_n    = {pb[0], pb[1], pb[2], pb[3], pb[4], pb[5], pb[6], pb[7]};
    high_n   = {pb[8], pb[9], pb[10], pb[11], pb[12], pb[13], pb[14], pb[15]};
  end

  assign q_take = q_valid && (!out_valid || pop);
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      if (q_info.length_error) begin
        frame_kind   <= KIND_READ_ID;
        checksum_ok  <= 1'b0;
        op_ok        <= 1'b0;
        length_error <= 1'b1;
        card_type    <= '0;
        card_number  <= '0;
        block_low    <= '0;
        block_high   <= '0;
      end else begin
        frame_kind   <= kind;
        checksum_ok  <= q_info.checksum_ok;
        op_ok        <= (q_info.status == STATUS_OK);
        length_error <= 1'b0;
        card_type    <= (kind == KIND_READ_ID) ? type_n : '0;
        card_number  <= (kind == KIND_READ_ID) ? number_n : '0;
        block_low    <= (kind == KIND_READ_BLOCK) ? low_n : '0;
        block_high   <= (kind == KIND_READ_BLOCK) ? high_n : '0;
      end
    end
  end

endmodule

[hw/rtl/card_reader_frame_receiver_top.sv]
// A result passes from the frame logic through the result queue and then the output register
// to the result ports; it waits in the queue while the output register holds an unpopped result.
// Throughput: one byte per cycle while full is low; full rises only once two results wait in the two-entry
// result queue behind an output register that was not popped.
// Reset: synchronous rst clears the frame state, the result queue and the output valid flag;
// the block is ready for a new frame in the first cycle after reset.
module card_reader_frame_receiver_top #(
  parameter int PAYLOAD_BYTES = crfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int QUEUE_DEPTH   = crfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  frame_kind,
  output logic        checksum_ok,
  output logic        op_ok,
  output logic        length_error,
  output logic [15:0] card_type,
  output logic [31:0] card_number,
  output logic [63:0] block_low,
  output logic [63:0] block_high
);
  import crfr_pkg::*;

  localparam int PayW   = PAYLOAD_BYTES * 8;
  localparam int QWidth = $bits(frame_info_t) + PayW;

  logic              accept;
  logic              rec_valid;
  frame_info_t       rec_info;
  logic [PayW-1:0]   rec_payload;
  logic              q_valid, q_take;
  logic [QWidth-1:0] q_data;
  frame_info_t       q_info;
  logic [PayW-1:0]   q_payload;

  assign accept = push && !full;

  crfr_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .rec_valid   (rec_valid),
    .rec_info    (rec_info),
    .rec_payload (rec_payload)
  );

  crfr_queue #(.WIDTH(QWidth), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (rec_valid),
    .wr_data  ({rec_info, rec_payload}),
    .rd_en    (q_take),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .full     (full)
  );

  assign q_info    = q_data[QWidth-1 -: $bits(frame_info_t)];
  assign q_payload = q_data[PayW-1:0];

  crfr_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_info       (q_info),
    .q_payload    (q_payload),
    .q_take       (q_take),
    .pop          (pop),
    .empty        (empty),
    .frame_kind   (frame_kind),
    .checksum_ok  (checksum_ok),
    .op_ok        (op_ok),
    .length_error (length_error),
    .card_type    (card_type),
    .card_number  (card_number),
    .block_low    (block_low),
    .block_high   (block_high)
  );

endmodule

[hw/rtl/crfr_checker.sv]
`include "card_reader_frame_receiver_top_macros.svh"

module crfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  frame_kind,
  input logic        checksum_ok,
  input logic        op_ok,
  input logic        length_error,
  input logic [15:0] card_type,
  input logic [31:0] card_number,
  input logic [63:0] block_low,
  input logic [63:0] block_high
);
  import crfr_pkg::*;

  // A rejected length carries nothing else.
  `CRFR_ASSERT_NOW(a_len_err_clean, clk, rst, !empty && length_error,
    frame_kind == KIND_READ_ID && !checksum_ok && !op_ok && card_type == '0 &&
    card_number == '0 && block_low == '0 && block_high == '0)

  `CRFR_ASSERT_NOW(a_card_only_id, clk, rst, !empty && frame_kind != KIND_READ_ID,
    card_type == '0 && card_number == '0)

  `CRFR_ASSERT_NOW(a_block_only_read, clk, rst, !empty && frame_kind != KIND_READ_BLOCK,
    block_low == '0 && block_high == '0)

  // The output register is refilled before the queue can back up.
  `CRFR_ASSERT_NOW(a_no_full_when_empty, clk, rst, empty, !full)

  `CRFR_ASSERT_NEXT(a_hold_result, clk, rst, !empty && !pop,
    !empty && $stable(frame_kind) && $stable(card_number) && $stable(block_low))

endmodule

bind card_reader_frame_receiver_top crfr_checker u_crfr_checker (.*);

[bench/testbench.sv]
module testbench;
  import crfr_pkg::*;

  localparam int KEPT_BYTES   = PAYLOAD_BYTES_DEF;
  localparam int KEPT_W       = $clog2(KEPT_BYTES);
  localparam int RANDOM_BYTES = 1250;
  localparam int MAX_IDLE     = 17;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_PAUSE  = 6;
  localparam int MAX_REPORTS  = 60;

  typedef struct packed {
    logic [1:0]  kind;
    logic        sum_ok;
    logic        status_ok;
    logic        len_err;
    logic [15:0] card_type;
    logic [31:0] card_number;
    logic [63:0] block_low;
    logic [63:0] block_high;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  rx_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  frame_kind;
  logic        checksum_ok;
  logic        op_ok;
  logic        length_error;
  logic [15:0] card_type;
  logic [31:0] card_number;
  logic [63:0] block_low;
  logic [63:0] block_high;

  card_reader_frame_receiver_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .empty        (empty),
    .pop          (pop),
    .frame_kind   (frame_kind),
    .checksum_ok  (checksum_ok),
    .op_ok        (op_ok),
    .length_error (length_error),
    .card_type    (card_type),
    .card_number  (card_number),
    .block_low    (block_low),
    .block_high   (block_high)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Deframer state as the predictor sees it.
  logic [7:0] frame_pos;
  logic [7:0] frame_len;
  logic [7:0] frame_xor;
  logic [7:0] frame_cmd;
  logic [7:0] frame_status;
  logic [7:0] kept_bytes [KEPT_BYTES];

  frame_result_t expected_frames [$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int sender_burst = 0;
  int reader_burst = 0;
  int hold_request = 0;

  function automatic void clear_frame();
    frame_pos = '0;
    frame_len = '0;
    frame_xor = '0;
    frame_cmd = '0;
    frame_status = '0;
    for (int i = 0; i < KEPT_BYTES; i++) kept_bytes[i] = '0;
  endfunction

  function automatic logic [7:0] kept(input int idx);
    return (idx < KEPT_BYTES) ? kept_bytes[KEPT_W'(idx)] : 8'h00;
  endfunction

  function automatic void predict_byte(input logic [7:0] b);
    frame_result_t r;
    logic [7:0] pos;
    pos = frame_pos;
    r = '0;
    if (pos == POS_LENGTH) begin
      frame_len = b;
      if (b < MIN_LENGTH) begin
        r.len_err = 1'b1;
        expected_frames.push_back(r);
        clear_frame();
        return;
      end
    end
    if (pos == POS_COMMAND) frame_cmd = b;
    if (pos == POS_STATUS) frame_status = b;
    if (pos >= POS_PAYLOAD && int'(pos - POS_PAYLOAD) < KEPT_BYTES)
      kept_bytes[KEPT_W'(pos - POS_PAYLOAD)] = b;
    if (pos >= POS_LENGTH && int'(pos) + 1 == int'(frame_len)) begin
      case (frame_cmd)
        CMD_READ_ID:     r.kind = KIND_READ_ID;
        CMD_READ_BLOCK:  r.kind = KIND_READ_BLOCK;
        CMD_WRITE_BLOCK: r.kind = KIND_WRITE_BLOCK;
        default:         r.kind = KIND_OTHER;
      endcase
      r.sum_ok = (~frame_xor == b);
      r.status_ok = (frame_status == STATUS_OK);
      if (r.kind == KIND_READ_ID) begin
        r.card_type = {kept(0), kept(1)};
        r.card_number = {kept(2), kept(3), kept(4), kept(5)};
      end
      if (r.kind == KIND_READ_BLOCK) begin
        for (int i = 0; i < 8; i++) begin
          r.block_low = {r.block_low[55:0], kept(i)};
          r.block_high = {r.block_high[55:0], kept(i + 8)};
        end
      end
      expected_frames.push_back(r);
      clear_frame();
      return;
    end
    frame_xor = frame_xor ^ b;
    frame_pos = pos + 8'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_frames.size() == 0) begin
      report_mismatch("result with no frame pending", '0, '0);
      return;
    end
    want = expected_frames.pop_front();
    if (frame_kind !== want.kind)
      report_mismatch("frame_kind", 64'(frame_kind), 64'(want.kind));
    if (checksum_ok !== want.sum_ok)
      report_mismatch("checksum_ok", 64'(checksum_ok), 64'(want.sum_ok));
    if (op_ok !== want.status_ok)
      report_mismatch("op_ok", 64'(op_ok), 64'(want.status_ok));
    if (length_error !== want.len_err)
      report_mismatch("length_error", 64'(length_error), 64'(want.len_err));
    if (card_type !== want.card_type)
      report_mismatch("card_type", 64'(card_type), 64'(want.card_type));
    if (card_number !== want.card_number)
      report_mismatch("card_number", 64'(card_number), 64'(want.card_number));
    if (block_low !== want.block_low) report_mismatch("block_low", block_low, want.block_low);
    if (block_high !== want.block_high)
      report_mismatch("block_high", block_high, want.block_high);
  endtask

  function automatic int draw_idle(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, MAX_IDLE);
  endfunction

  // The request stays high from one byte to the next when no idle cycles are drawn.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_idle(sender_burst);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] body [$], input bit good_sum);
    logic [7:0] acc;
    acc = '0;
    foreach (body[i]) begin
      acc = acc ^ body[i];
      send_byte(body[i]);
    end
    if (good_sum) send_byte(~acc);
    else send_byte(~acc ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic idle_sender();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // Brings the deframer back to the start of a frame, keeping the flush short.
  task automatic resync();
    while (frame_pos != POS_START) begin
      if (frame_pos == POS_LENGTH) send_byte(8'($urandom_range(0, 23)));
      else send_byte(8'($urandom));
    end
  endtask

  task automatic send_random_frame(input int len);
    logic [7:0] body [$];
    logic [7:0] b;
    int pick;
    if (len < 3) begin
      send_byte(8'($urandom));
      send_byte(8'(len));
      return;
    end
    for (int i = 0; i < len - 1; i++) begin
      b = 8'($urandom);
      if (i == 1) b = 8'(len);
      if (i == 2) begin
        pick = $urandom_range(0, 4);
        case (pick)
          0: b = CMD_READ_ID;
          1: b = CMD_READ_BLOCK;
          2: b = CMD_WRITE_BLOCK;
          default: b = 8'($urandom);
        endcase
      end
      if (i == 4 && $urandom_range(0, 9) < 6) b = STATUS_OK;
      body.push_back(b);
    end
    send_frame(body, $urandom_range(0, 99) < 85);
  endtask

  task automatic test_short_lengths();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h02);
    idle_sender();
    wait_drained();
  endtask

  task automatic test_short_frames();
    // A three-byte frame: the checksum lands on the command position.
    send_frame('{8'h5A, 8'h03}, 1'b1);
    // A five-byte frame: the checksum lands on the status position.
    send_frame('{8'hFF, 8'h05, CMD_WRITE_BLOCK, 8'h77}, 1'b1);
    idle_sender();
    wait_drained();
  endtask

  task automatic test_read_id_frame();
    // Card fields come out raw even though the checksum fails.
    send_frame('{8'h00, 8'h0B, CMD_READ_ID, 8'h80, STATUS_OK,
                 8'hFF, 8'h01, 8'hDE, 8'hAD, 8'hBE}, 1'b0);
    idle_sender();
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_request = 1;
    sender_burst = 200;
    repeat (20) send_random_frame($urandom_range(0, 3));
    idle_sender();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int r;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        resync();
      end else if (r < 16) begin
        send_random_frame($urandom_range(0, 2));
      end else if (r < 19) begin
        send_random_frame($urandom_range(22, 255));
      end else if (r < 45) begin
        r = $urandom_range(0, 2);
        send_random_frame(r == 0 ? 11 : (r == 1 ? 21 : 22));
      end else begin
        send_random_frame($urandom_range(3, 24));
      end
      if ($urandom_range(0, 99) == 0) hold_request = 1;
    end
    idle_sender();
    wait_drained();
  endtask

  initial begin
    clear_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_short_lengths();
    test_short_frames();
    test_read_id_frame();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: random pop gaps, plus a long hold-off whenever one is requested.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = draw_idle(reader_burst);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if (hold_request != 0) begin
        hold_request = 0;
        pop <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_result();
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
